[hw/rtl/gml_pkg.sv]
package gml_pkg;

  localparam int ID_W      = 5;
  localparam int HB_W      = 32;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int MAX_OUT   = 32;
  localparam int SNAP_N_W  = 6;

  localparam logic [OP_W-1:0] OP_MERGE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_SNAP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_AFTER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELETE_AFTER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALTED       = 2'd3;

  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_VIEW   = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] node_id;
    logic [HB_W-1:0] peer_heartbeat;
    logic [ID_W-1:0] pick;
  } gml_in_t;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] node_id_out;
    logic [HB_W-1:0] heartbeat_out;
    logic            found;
    logic            last;
  } gml_out_t;

  // status of the shared subtract and compare unit
  typedef struct packed {
    logic borrow;
    logic over_fail;
    logic over_del;
  } gml_alu_st_t;

endpackage

[hw/rtl/gml_ram.sv]
module gml_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/gml_alu.sv]
module gml_alu (
  input  logic [gml_pkg::HB_W-1:0] a,
  input  logic [gml_pkg::HB_W-1:0] b,
  input  logic [gml_pkg::HB_W-1:0] lim_fail,
  input  logic [gml_pkg::HB_W-1:0] lim_del,
  output gml_pkg::gml_alu_st_t     st
);
  import gml_pkg::*;

  logic [HB_W:0]   diff;
  logic [HB_W-1:0] age;

  // a - b wraps modulo 2^32; the borrow tells a < b
  assign diff         = {1'b0, a} - {1'b0, b};
  assign age          = diff[HB_W-1:0];
  assign st.borrow    = diff[HB_W];
  assign st.over_fail = age > lim_fail;
  assign st.over_del  = age > lim_del;

endmodule

[hw/rtl/gossip_membership_table.sv]
// Gossip membership table with heartbeat failure detection, one entry per node id.
// Items run one at a time and in_ready is low while one is in progress. A merge reads
// its entry RAM word, then compares and writes. A tick and a snapshot walk the table
// one entry per cycle through the single read port of the entry RAM, with the shared
// subtract/compare unit working out each entry's age on a tick. A snapshot stalls on
// an entry to send, and both on the final result, until the output is free. The next
// item may be accepted while the last result still waits in the output register.
// Items accepted while halted, merges for the own id and unknown ops are
// dropped without results. Configuration writes are always taken (cfg_ready is high).
module gossip_membership_table #(
  parameter int NODES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gml_pkg::gml_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gml_pkg::gml_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gml_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gml_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int EXT_W = 7;
  localparam int RAM_W = 2 * HB_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
  localparam logic [EXT_W-1:0] NODES_EXT = EXT_W'(NODES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MERGE = 3'd1;
  localparam logic [2:0] S_TSCAN = 3'd2;
  localparam logic [2:0] S_TOUT  = 3'd3;
  localparam logic [2:0] S_SSCAN = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [ID_W-1:0]  own_id_r, own_id_nxt;
  logic [HB_W-1:0]  fail_after_r, fail_after_nxt;
  logic [HB_W-1:0]  delete_after_r, delete_after_nxt;
  logic             halted_r, halted_nxt;
  logic [HB_W-1:0]  local_hb_r, local_hb_nxt;
  logic [NODES-1:0] present_r, present_nxt;
  logic [NODES-1:0] failed_r, failed_nxt;
  gml_in_t          item_r, item_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [IDX_W:0]   seen_r, seen_nxt;
  logic             tfound_r, tfound_nxt;
  logic [IDX_W-1:0] tid_r, tid_nxt;
  logic [SNAP_N_W-1:0] snap_n_r, snap_n_nxt;
  gml_out_t         pend_r, pend_nxt;
  gml_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             acc;
  logic             out_free;
  logic [EXT_W-1:0] own_ext;
  logic [EXT_W-1:0] in_id_ext;
  logic [EXT_W-1:0] item_id_ext;
  logic [EXT_W-1:0] p_ext;
  logic [IDX_W-1:0] item_idx;
  logic [IDX_W-1:0] in_idx;
  logic             p_own;
  logic             p_last;
  logic             p_slot;
  logic             snap_elig;
  logic [HB_W-1:0]  own_hb;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [RAM_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [RAM_W-1:0] ram_rdata;

  logic [HB_W-1:0]  alu_a;
  logic [HB_W-1:0]  alu_b;
  gml_alu_st_t      alu_st;

  // entry RAM: heartbeat in the upper half, last update time in the lower half
  gml_ram #(
    .WIDTH(RAM_W),
    .DEPTH(NODES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  gml_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .lim_fail(fail_after_r),
    .lim_del (delete_after_r),
    .st      (alu_st)
  );

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign own_ext     = EXT_W'(own_id_r);
  assign in_id_ext   = EXT_W'(in_data.node_id);
  assign item_id_ext = EXT_W'(item_r.node_id);
  assign p_ext       = EXT_W'(p_r);
  assign in_idx      = in_id_ext[IDX_W-1:0];
  assign item_idx    = item_id_ext[IDX_W-1:0];
  assign p_own       = (p_ext == own_ext);
  assign p_last      = (p_r == LAST_IDX);
  assign own_hb      = (local_hb_r == '0) ? HB_W'(1) : local_hb_r;

  // slot still present after this tick's ageing; the own slot always is
  assign p_slot    = p_own || (present_r[p_r] && !alu_st.over_del);
  assign snap_elig = !p_own && present_r[p_r] && !failed_r[p_r]
                     && (snap_n_r < SNAP_N_W'(MAX_OUT));

  always_comb begin
    alu_a = local_hb_r;
    alu_b = ram_rdata[HB_W-1:0];
    if (state_r == S_MERGE) begin
      alu_a = ram_rdata[RAM_W-1:HB_W];
      alu_b = item_r.peer_heartbeat;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    own_id_nxt       = own_id_r;
    fail_after_nxt   = fail_after_r;
    delete_after_nxt = delete_after_r;
    halted_nxt       = halted_r;
    local_hb_nxt     = local_hb_r;
    present_nxt      = present_r;
    failed_nxt       = failed_r;
    item_nxt         = item_r;
    p_nxt            = p_r;
    seen_nxt         = seen_r;
    tfound_nxt       = tfound_r;
    tid_nxt          = tid_r;
    snap_n_nxt       = snap_n_r;
    pend_nxt         = pend_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    ram_we           = 1'b0;
    ram_waddr        = item_idx;
    ram_wdata        = {item_r.peer_heartbeat, local_hb_r};
    ram_raddr        = '0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ID:       own_id_nxt       = cfg_data[ID_W-1:0];
        REG_FAIL_AFTER:   fail_after_nxt   = cfg_data[HB_W-1:0];
        REG_DELETE_AFTER: delete_after_nxt = cfg_data[HB_W-1:0];
        REG_HALTED:       halted_nxt       = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_data.op == OP_MERGE) begin
          ram_raddr = in_idx;
        end
        if (acc && !halted_r) begin
          item_nxt = in_data;
          p_nxt    = '0;
          case (in_data.op)
            OP_MERGE: begin
              if (in_id_ext != own_ext && in_id_ext < NODES_EXT) begin
                state_nxt = S_MERGE;
              end
            end
            OP_TICK: begin
              local_hb_nxt = local_hb_r + HB_W'(1);
              seen_nxt     = '0;
              tfound_nxt   = 1'b0;
              tid_nxt      = '0;
              state_nxt    = S_TSCAN;
            end
            OP_SNAP: begin
              pend_nxt   = '{kind: KIND_VIEW, node_id_out: own_id_r, heartbeat_out: own_hb,
                             found: 1'b1, last: 1'b0};
              snap_n_nxt = SNAP_N_W'(1);
              state_nxt  = S_SSCAN;
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        if (!present_r[item_idx] || alu_st.borrow) begin
          ram_we                = 1'b1;
          present_nxt[item_idx] = 1'b1;
          failed_nxt[item_idx]  = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_TSCAN: begin
        ram_raddr = p_r + IDX_W'(1);
        if (!p_own && present_r[p_r]) begin
          if (alu_st.over_fail) begin
            failed_nxt[p_r] = 1'b1;
          end
          if (alu_st.over_del) begin
            present_nxt[p_r] = 1'b0;
          end
        end
        if (p_slot) begin
          if (!tfound_r && EXT_W'(seen_r) == EXT_W'(item_r.pick)) begin
            tfound_nxt = 1'b1;
            tid_nxt    = p_r;
          end
          seen_nxt = seen_r + (IDX_W + 1)'(1);
        end
        if (p_last) begin
          state_nxt = S_TOUT;
        end else begin
          p_nxt = p_r + IDX_W'(1);
        end
      end
      S_TOUT: begin
        if (out_free) begin
          out_nxt = '{kind: KIND_TARGET,
                      node_id_out: tfound_r ? ID_W'(tid_r) : '0,
                      heartbeat_out: '0, found: tfound_r, last: 1'b1};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SSCAN: begin
        ram_raddr = p_r;
        if (!snap_elig || out_free) begin
          ram_raddr = p_r + IDX_W'(1);
          if (snap_elig) begin
            // hand the held entry on; the new one waits until we know if it is final
            out_nxt       = pend_r;
            out_valid_nxt = 1'b1;
            pend_nxt      = '{kind: KIND_VIEW, node_id_out: p_ext[ID_W-1:0],
                              heartbeat_out: ram_rdata[RAM_W-1:HB_W],
                              found: 1'b1, last: 1'b0};
            snap_n_nxt    = snap_n_r + SNAP_N_W'(1);
          end
          if (p_last) begin
            state_nxt = S_SEND;
          end else begin
            p_nxt = p_r + IDX_W'(1);
          end
        end
      end
      S_SEND: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      own_id_r       <= '0;
      fail_after_r   <= HB_W'(5);
      delete_after_r <= HB_W'(10);
      halted_r       <= 1'b0;
      local_hb_r     <= '0;
      present_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      own_id_r       <= own_id_nxt;
      fail_after_r   <= fail_after_nxt;
      delete_after_r <= delete_after_nxt;
      halted_r       <= halted_nxt;
      local_hb_r     <= local_hb_nxt;
      present_r      <= present_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    failed_r <= failed_nxt;
    item_r   <= item_nxt;
    p_r      <= p_nxt;
    seen_r   <= seen_nxt;
    tfound_r <= tfound_nxt;
    tid_r    <= tid_nxt;
    snap_n_r <= snap_n_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  a_merge_sets_present: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> present_r[$past(ram_waddr)])
    else $error("merged entry not present");

  a_hb_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && !halted_r && in_data.op == OP_TICK) |=> $stable(local_hb_r))
    else $error("local heartbeat moved without a tick");

  a_target_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOUT && out_free) |=>
      (out_valid_r && out_r.kind == KIND_TARGET && out_r.last))
    else $error("tick did not deliver a final target result");

  a_snap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SSCAN || state_r == S_SEND) |-> snap_n_r <= SNAP_N_W'(MAX_OUT))
    else $error("snapshot overran its result limit");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import gml_pkg::*;

  localparam int NODES          = 32;
  localparam int FAIL_AFTER_RST = 5;
  localparam int DEL_AFTER_RST  = 10;
  localparam int SETTLE_CYC     = 2 * NODES;
  localparam int ROUNDS_PER_SET = 44;
  localparam int CYCLE_LIMIT    = 1_000_000;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  gml_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  gml_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OWN_ID;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  gossip_membership_table #(.NODES(NODES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // local copy of the registers and of the membership table
  logic [ID_W-1:0] own_q;
  logic [HB_W-1:0] fail_lim;
  logic [HB_W-1:0] del_lim;
  logic            halted_q;
  logic [HB_W-1:0] local_hb;
  logic            peer_present [NODES];
  logic [HB_W-1:0] peer_hb      [NODES];
  logic [HB_W-1:0] peer_seen_at [NODES];
  logic            peer_failed  [NODES];

  gml_out_t        due_results[$];
  gml_in_t         pending_items[$];
  logic [HB_W-1:0] sent_hb [NODES];

  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;
  int in_gap    = 0;
  int out_hold  = 0;
  int errors    = 0;
  int stim_cnt  = 0;
  int cycles    = 0;

  // apply one accepted item to the table and queue the results it causes
  function automatic void table_step(gml_in_t it);
    gml_out_t        r;
    int              seen;
    logic [HB_W-1:0] age;
    if (halted_q) return;
    case (it.op)
      OP_MERGE: begin
        if (it.node_id != own_q &&
            (!peer_present[it.node_id] || peer_hb[it.node_id] < it.peer_heartbeat)) begin
          peer_present[it.node_id] = 1'b1;
          peer_hb[it.node_id]      = it.peer_heartbeat;
          peer_seen_at[it.node_id] = local_hb;
          peer_failed[it.node_id]  = 1'b0;
        end
      end
      OP_TICK: begin
        local_hb = local_hb + 1;
        for (int i = 0; i < NODES; i++) begin
          if (i != own_q && peer_present[i]) begin
            age = local_hb - peer_seen_at[i];
            if (age > fail_lim) peer_failed[i] = 1'b1;
            if (age > del_lim) peer_present[i] = 1'b0;
          end
        end
        r      = '0;
        r.kind = KIND_TARGET;
        r.last = 1'b1;
        seen   = 0;
        for (int i = 0; i < NODES; i++) begin
          if ((i == own_q || peer_present[i]) && !r.found) begin
            if (seen == it.pick) begin
              r.node_id_out = ID_W'(i);
              r.found       = 1'b1;
            end
            seen++;
          end
        end
        due_results.push_back(r);
      end
      OP_SNAP: begin
        // own entry first, its heartbeat never below one
        r               = '0;
        r.kind          = KIND_VIEW;
        r.node_id_out   = own_q;
        r.heartbeat_out = (local_hb == '0) ? HB_W'(1) : local_hb;
        r.found         = 1'b1;
        for (int i = 0; i < NODES; i++) begin
          if (i != own_q && peer_present[i] && !peer_failed[i]) begin
            due_results.push_back(r);
            r.node_id_out   = ID_W'(i);
            r.heartbeat_out = peer_hb[i];
          end
        end
        r.last = 1'b1;
        due_results.push_back(r);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : item_drive
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        table_step(in_data);
        in_gap = in_burst ? 0 : $urandom_range(0, 5);
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    gml_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: kind=%0d id=%0d hb=%h found=%0d last=%0d",
                     out_data.kind, out_data.node_id_out, out_data.heartbeat_out,
                     out_data.found, out_data.last);
        end else begin
          want = due_results.pop_front();
          if (out_data.kind !== want.kind || out_data.node_id_out !== want.node_id_out ||
              out_data.heartbeat_out !== want.heartbeat_out ||
              out_data.found !== want.found || out_data.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected kind=%0d id=%0d hb=%h found=%0d last=%0d,",
                        " got kind=%0d id=%0d hb=%h found=%0d last=%0d"},
                       want.kind, want.node_id_out, want.heartbeat_out, want.found,
                       want.last, out_data.kind, out_data.node_id_out,
                       out_data.heartbeat_out, out_data.found, out_data.last);
          end
        end
        out_hold = out_burst ? 0 : $urandom_range(0, 5);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_OWN_ID:       own_q    = val[ID_W-1:0];
      REG_FAIL_AFTER:   fail_lim = val;
      REG_DELETE_AFTER: del_lim  = val;
      REG_HALTED:       halted_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_membership(logic [ID_W-1:0] own, logic [HB_W-1:0] fail_n,
                                logic [HB_W-1:0] del_n);
    write_reg(REG_OWN_ID, CFG_DAT_W'(own));
    write_reg(REG_FAIL_AFTER, fail_n);
    write_reg(REG_DELETE_AFTER, del_n);
  endtask

  // wait for every transfer to finish, then allow for a merge still in flight
  task automatic settle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic void add_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                   logic [HB_W-1:0] hb, logic [ID_W-1:0] pick);
    gml_in_t it;
    it.op             = op;
    it.node_id        = id;
    it.peer_heartbeat = hb;
    it.pick           = pick;
    pending_items.push_back(it);
    if (op != OP_UNKNOWN && !halted_q && !(op == OP_MERGE && id == own_q)) stim_cnt++;
  endfunction

  // a few peer updates, one heartbeat tick and sometimes a view
  task automatic gossip_round();
    int              n;
    logic [ID_W-1:0] id;
    logic [HB_W-1:0] hb;
    n = $urandom_range(0, 5);
    repeat (n) begin
      id = ID_W'($urandom_range(0, NODES - 1));
      case ($urandom_range(0, 9))
        0: begin
          sent_hb[id] = $urandom;
          hb = sent_hb[id];
        end
        1: hb = sent_hb[id] - $urandom_range(1, 3);
        default: begin
          sent_hb[id] = sent_hb[id] + $urandom_range(0, 2);
          hb = sent_hb[id];
        end
      endcase
      add_item(OP_MERGE, id, hb, ID_W'($urandom));
    end
    add_item(OP_TICK, ID_W'($urandom), $urandom,
             ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 6)));
    if ($urandom_range(0, 2) == 0)
      add_item(OP_SNAP, ID_W'($urandom), $urandom, ID_W'($urandom));
  endtask

  initial begin : stimulus
    int              stop;
    int              k;
    logic [ID_W-1:0] own;
    logic [HB_W-1:0] fail_n;
    logic [HB_W-1:0] del_n;

    own_q    = '0;
    fail_lim = FAIL_AFTER_RST;
    del_lim  = DEL_AFTER_RST;
    halted_q = 1'b0;
    local_hb = '0;
    for (int i = 0; i < NODES; i++) begin
      peer_present[i] = 1'b0;
      peer_hb[i]      = '0;
      peer_seen_at[i] = '0;
      peer_failed[i]  = 1'b0;
      sent_hb[i]      = $urandom_range(0, 100);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset settings
    add_item(OP_SNAP, '0, '0, '0);
    add_item(OP_TICK, '0, '0, 5'd0);
    add_item(OP_TICK, '0, '0, 5'd1);
    add_item(OP_MERGE, 5'd1, 32'd0, '0);
    add_item(OP_MERGE, 5'd1, 32'd0, '0);
    add_item(OP_MERGE, 5'd1, 32'd5, '0);
    add_item(OP_MERGE, 5'd1, 32'd3, '0);
    add_item(OP_MERGE, 5'd0, 32'hFFFF_FFFF, '1);
    add_item(OP_MERGE, 5'd31, 32'hFFFF_FFFF, '0);
    add_item(OP_MERGE, 5'd2, 32'd7, '0);
    add_item(OP_UNKNOWN, 5'd31, 32'hFFFF_FFFF, 5'd31);
    add_item(OP_SNAP, '1, '1, '1);
    add_item(OP_TICK, '0, '0, 5'd3);
    add_item(OP_TICK, '1, '1, 5'd31);
    repeat (5) add_item(OP_TICK, '0, '0, 5'd2);
    add_item(OP_MERGE, 5'd2, 32'd8, '0);
    add_item(OP_SNAP, '0, '0, '0);
    repeat (4) add_item(OP_TICK, '0, '0, 5'd1);
    add_item(OP_SNAP, '0, '0, '0);
    settle();

    // halted host: everything dropped, nothing changes
    write_reg(REG_HALTED, 32'd1);
    add_item(OP_MERGE, 5'd3, 32'd1, '0);
    add_item(OP_TICK, '0, '0, '0);
    add_item(OP_SNAP, '0, '0, '0);
    settle();
    write_reg(REG_HALTED, 32'd0);
    add_item(OP_SNAP, '0, '0, '0);
    settle();

    for (int set = 0; set < 8; set++) begin
      case (set)
        0: begin own = 5'd31; fail_n = '0; del_n = '0; end
        1: begin own = 5'd0; fail_n = '1; del_n = '1; end
        2: begin own = ID_W'($urandom); fail_n = 3; del_n = 8; end
        3: begin own = ID_W'($urandom); fail_n = 8; del_n = 3; end
        4: begin own = 5'd17; fail_n = 2; del_n = 20; end
        5: begin
          own    = ID_W'($urandom);
          fail_n = $urandom_range(0, 12);
          del_n  = $urandom_range(0, 12);
        end
        6: begin own = ID_W'($urandom); fail_n = $urandom; del_n = $urandom; end
        default: begin own = 5'd5; fail_n = 1; del_n = 1; end
      endcase
      set_membership(own, fail_n, del_n);
      in_burst  = (set % 3 == 1);
      out_burst = (set % 4 == 2);
      stop = stim_cnt + ROUNDS_PER_SET;
      while (stim_cnt < stop) begin
        k = $urandom_range(0, 19);
        if (k < 15) begin
          gossip_round();
        end else if (k < 19) begin
          add_item(OP_W'($urandom_range(0, 3)), ID_W'($urandom), $urandom, ID_W'($urandom));
        end else begin
          // fill the whole table, then ask for the full view
          for (int i = 0; i < NODES; i++) begin
            sent_hb[i] = sent_hb[i] + 1;
            add_item(OP_MERGE, ID_W'(i), sent_hb[i], '0);
          end
          add_item(OP_SNAP, '0, '0, '0);
        end
      end
      settle();
    end

    if (errors == 0 && due_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
